// ----- hdl/rstmc_pkg.sv -----
// ----------------------------------------------------------------------------
// rstmc_pkg
// shared types and constants of the random spanning tree maze carver
// ----------------------------------------------------------------------------
`default_nettype none

package rstmc_pkg;

    localparam int MAX_NODE_ROWS = 16;
    localparam int MAX_NODE_COLS = 16;
    localparam int NODE_CAP      = MAX_NODE_ROWS * MAX_NODE_COLS;
    localparam int EDGE_CAP      = 2 * NODE_CAP;
    localparam int NODE_W        = $clog2(NODE_CAP);
    localparam int EDGE_W        = $clog2(EDGE_CAP);
    localparam int ECNT_W        = $clog2(EDGE_CAP + 1);
    localparam int JCNT_W        = $clog2(NODE_CAP + 1);
    localparam int RDIM_W        = $clog2(MAX_NODE_ROWS + 1);
    localparam int CDIM_W        = $clog2(MAX_NODE_COLS + 1);
    localparam int RND_W         = 31;
    localparam int COORD_W       = 5;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BUILD,
        ST_INIT,
        ST_MOD,
        ST_READ,
        ST_SHIFT,
        ST_FIND_A,
        ST_FIND_B,
        ST_JOIN,
        ST_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic start_latch;
        logic build;
        logic init;
        logic mod_load;
        logic mod_step;
        logic read_pick;
        logic shift;
        logic find_a_load;
        logic find_b_load;
        logic find_step;
        logic join_set;
        logic res_start;
        logic res_error;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic build_done;
        logic init_done;
        logic mod_done;
        logic shift_done;
        logic find_done;
        logic coord_done;
        logic runnable;
    } sts_t;

    function automatic logic [RDIM_W-1:0] nodes_rows(input logic [4:0] cells);
        logic [4:0] c;
        logic [5:0] n;
        c = (cells == 5'd0) ? 5'd1 : cells;
        if (!c[0]) c = c - 5'd1;
        n = {2'b00, c[4:1]} + 6'd1;
        if (n > 6'(MAX_NODE_ROWS)) n = 6'(MAX_NODE_ROWS);
        return RDIM_W'(n);
    endfunction

    function automatic logic [CDIM_W-1:0] nodes_cols(input logic [4:0] cells);
        logic [4:0] c;
        logic [5:0] n;
        c = (cells == 5'd0) ? 5'd1 : cells;
        if (!c[0]) c = c - 5'd1;
        n = {2'b00, c[4:1]} + 6'd1;
        if (n > 6'(MAX_NODE_COLS)) n = 6'(MAX_NODE_COLS);
        return CDIM_W'(n);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rstmc_ctrl.sv -----
// ----------------------------------------------------------------------------
// rstmc_ctrl
// sequencer for start and step items of the maze carver
// ----------------------------------------------------------------------------
`default_nettype none

module rstmc_ctrl
    import rstmc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    input  wire logic in_op,
    input  wire logic out_fire,
    input  wire sts_t sts,
    output cmd_t      cmd,
    output logic      busy,
    output logic      out_valid
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    if (in_op == OP_START)
                    begin
                        cmd.start_latch = 1'b1;
                        state_next = ST_BUILD;
                    end
                    else if (sts.runnable)
                    begin
                        cmd.mod_load = 1'b1;
                        state_next = ST_MOD;
                    end
                    else
                    begin
                        cmd.res_error = 1'b1;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_BUILD:
            begin
                cmd.build = 1'b1;
                if (sts.build_done) state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init = 1'b1;
                if (sts.init_done)
                begin
                    cmd.res_start = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_done) state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read_pick = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_done)
                begin
                    cmd.find_a_load = 1'b1;
                    state_next = ST_FIND_A;
                end
            end
            ST_FIND_A:
            begin
                cmd.find_step = 1'b1;
                if (sts.find_done)
                begin
                    cmd.find_b_load = 1'b1;
                    state_next = ST_FIND_B;
                end
            end
            ST_FIND_B:
            begin
                cmd.find_step = 1'b1;
                if (sts.find_done && sts.coord_done) state_next = ST_JOIN;
            end
            ST_JOIN:
            begin
                cmd.join_set = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_fire) state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> state_reg == ST_IDLE)
        else $error("item accepted while busy");
    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !busy || state_reg == ST_OUT)
        else $error("result shown outside output state");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !out_fire) |=> state_reg == ST_OUT)
        else $error("result dropped");
`endif

endmodule

`default_nettype wire

// ----- hdl/rstmc_dp.sv -----
// ----------------------------------------------------------------------------
// rstmc_dp
// edge list, union-find store, modulo unit and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module rstmc_dp
    import rstmc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    input  wire logic                  cfg_fire,
    input  wire logic                  cfg_index,
    input  wire logic [4:0]            cfg_data,
    input  wire logic [RND_W-1:0]      rnd,
    output sts_t                       sts,
    output logic                       res_joined,
    output logic [COORD_W-1:0]         res_head_row,
    output logic [COORD_W-1:0]         res_head_col,
    output logic [COORD_W-1:0]         res_tail_row,
    output logic [COORD_W-1:0]         res_tail_col,
    output logic [COORD_W-1:0]         res_passage_row,
    output logic [COORD_W-1:0]         res_passage_col,
    output logic                       res_finished,
    output logic                       res_error
);

    logic [4:0] rows_cfg_reg, cols_cfg_reg;
    logic [RDIM_W-1:0] grows_reg;
    logic [CDIM_W-1:0] gcols_reg;
    logic [JCNT_W-1:0] ntotal_reg;
    logic [ECNT_W-1:0] etotal_reg;
    logic [JCNT_W-1:0] jtotal_reg;
    logic              started_reg;

    logic [2*NODE_W-1:0] edge_mem [EDGE_CAP];
    logic [NODE_W-1:0]   par_mem  [NODE_CAP];

    // build walk
    logic [RDIM_W-1:0] br_reg;
    logic [CDIM_W-1:0] bc_reg;
    logic              bdown_reg;
    logic [NODE_W-1:0] bnode_reg;
    logic [JCNT_W-1:0] icnt_reg;

    // modulo
    logic [RND_W-1:0]  rem_reg;
    logic [RND_W+ECNT_W-1:0] div_reg;
    logic [4:0]        mcnt_reg;

    // shift
    logic [EDGE_W-1:0] sptr_reg;
    logic [2*NODE_W-1:0] erd_reg;
    logic                sphase_reg;

    // find
    logic [NODE_W-1:0] fv_reg;
    logic [NODE_W-1:0] ra_reg;
    logic              fphase_reg;
    logic [NODE_W-1:0] prd_reg;

    logic finished_now;
    assign finished_now = started_reg && ((JCNT_W+1)'(jtotal_reg) + 1'b1 >=
                          {1'b0, ntotal_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= 5'd31;
            cols_cfg_reg <= 5'd31;
            grows_reg    <= RDIM_W'(1);
            gcols_reg    <= CDIM_W'(1);
            ntotal_reg   <= JCNT_W'(1);
            etotal_reg   <= '0;
            jtotal_reg   <= '0;
            started_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_fire && cfg_index == CFG_ROWS) rows_cfg_reg <= cfg_data;
            if (cfg_fire && cfg_index == CFG_COLS) cols_cfg_reg <= cfg_data;
            if (cmd.start_latch)
            begin
                grows_reg  <= nodes_rows(rows_cfg_reg);
                gcols_reg  <= nodes_cols(cols_cfg_reg);
                ntotal_reg <= JCNT_W'(nodes_rows(rows_cfg_reg)) *
                              JCNT_W'(nodes_cols(cols_cfg_reg));
                etotal_reg <= '0;
                jtotal_reg <= '0;
                started_reg <= 1'b1;
            end
            if (cmd.build && !sts.build_done)
            begin
                if (bdown_reg ? (br_reg + 1'b1 < grows_reg)
                              : ({1'b0, bc_reg} + 1'b1 < {1'b0, gcols_reg}))
                    etotal_reg <= etotal_reg + 1'b1;
            end
            if (cmd.read_pick) etotal_reg <= etotal_reg - 1'b1;
            if (cmd.join_set && ra_reg != fv_reg) jtotal_reg <= jtotal_reg + 1'b1;
        end
    end

    // build: each node is visited for its right edge and then for its down edge
    assign sts.build_done = (br_reg == grows_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.start_latch)
        begin
            br_reg    <= '0;
            bc_reg    <= '0;
            bdown_reg <= 1'b0;
            bnode_reg <= '0;
            icnt_reg  <= '0;
        end
        else if (cmd.build && !sts.build_done)
        begin
            if (!bdown_reg && ({1'b0, bc_reg} + 1'b1 < {1'b0, gcols_reg}))
                edge_mem[etotal_reg[EDGE_W-1:0]] <= {bnode_reg, bnode_reg + 1'b1};
            if (bdown_reg && (br_reg + 1'b1 < grows_reg))
                edge_mem[etotal_reg[EDGE_W-1:0]] <=
                    {bnode_reg, bnode_reg + NODE_W'(gcols_reg)};
            bdown_reg <= ~bdown_reg;
            if (bdown_reg)
            begin
                bnode_reg <= bnode_reg + 1'b1;
                if ({1'b0, bc_reg} + 1'b1 == {1'b0, gcols_reg})
                begin
                    bc_reg <= '0;
                    br_reg <= br_reg + 1'b1;
                end
                else
                begin
                    bc_reg <= bc_reg + 1'b1;
                end
            end
        end
        else if (cmd.init)
        begin
            par_mem[icnt_reg[NODE_W-1:0]] <= icnt_reg[NODE_W-1:0];
            icnt_reg <= icnt_reg + 1'b1;
        end
        else if (cmd.shift && sphase_reg)
        begin
            edge_mem[sptr_reg] <= erd_reg;
        end
        else if (cmd.join_set && ra_reg != fv_reg)
        begin
            par_mem[fv_reg] <= ra_reg;
        end
    end

    assign sts.init_done = (icnt_reg + 1'b1 >= ntotal_reg);

    // restoring remainder, one bit a cycle
    assign sts.mod_done = (mcnt_reg == 5'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.mod_load)
        begin
            rem_reg  <= rnd;
            div_reg  <= {etotal_reg, {RND_W{1'b0}}} >> 1;
            mcnt_reg <= 5'(RND_W);
        end
        else if (cmd.mod_step && !sts.mod_done)
        begin
            if ((RND_W+ECNT_W)'(rem_reg) >= div_reg)
                rem_reg <= RND_W'((RND_W+ECNT_W)'(rem_reg) - div_reg);
            div_reg  <= div_reg >> 1;
            mcnt_reg <= mcnt_reg - 1'b1;
        end
    end

    // erase: read then write the next entry one down
    logic [EDGE_W-1:0] pick;
    logic [2*NODE_W-1:0] picked_reg;
    assign pick = rem_reg[EDGE_W-1:0];
    assign sts.shift_done = !sphase_reg && ({1'b0, sptr_reg} >= etotal_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.read_pick)
        begin
            picked_reg <= edge_mem[pick];
            sptr_reg   <= pick;
            sphase_reg <= 1'b0;
        end
        else if (cmd.shift && !sts.shift_done)
        begin
            if (!sphase_reg)
                erd_reg <= edge_mem[sptr_reg + 1'b1];
            else
                sptr_reg <= sptr_reg + 1'b1;
            sphase_reg <= ~sphase_reg;
        end
    end

    // root search, read then compare
    assign sts.find_done = fphase_reg && (prd_reg == fv_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.find_a_load)
        begin
            fv_reg     <= picked_reg[2*NODE_W-1:NODE_W];
            fphase_reg <= 1'b0;
        end
        else if (cmd.find_b_load)
        begin
            ra_reg     <= fv_reg;
            fv_reg     <= picked_reg[NODE_W-1:0];
            fphase_reg <= 1'b0;
        end
        else if (cmd.find_step && !sts.find_done)
        begin
            if (!fphase_reg)
                prd_reg <= par_mem[fv_reg];
            else
                fv_reg <= prd_reg;
            fphase_reg <= ~fphase_reg;
        end
    end

    assign sts.runnable = started_reg && !finished_now && (etotal_reg != '0);

    // node index to coordinates by counting
    logic [NODE_W-1:0] a_node, b_node;
    logic [RDIM_W-1:0] ar, brr;
    logic [CDIM_W-1:0] ac, bcc;
    logic              right_edge;
    assign a_node = picked_reg[2*NODE_W-1:NODE_W];
    assign b_node = picked_reg[NODE_W-1:0];
    logic [RDIM_W-1:0] arow_reg;
    logic [NODE_W-1:0] acc_reg;

    assign sts.coord_done = ((NODE_W+1)'(acc_reg) + (NODE_W+1)'(gcols_reg) >
                             (NODE_W+1)'(a_node));

    always_ff @(posedge clk)
    begin
        if (cmd.read_pick)
        begin
            arow_reg <= '0;
            acc_reg  <= '0;
        end
        else if (cmd.shift || cmd.find_step)
        begin
            if (!sts.coord_done)
            begin
                acc_reg  <= acc_reg + NODE_W'(gcols_reg);
                arow_reg <= arow_reg + 1'b1;
            end
        end
    end
    assign ar  = arow_reg;
    assign ac  = CDIM_W'(a_node - acc_reg);
    // b lies one right or one down of a
    assign right_edge = (gcols_reg != CDIM_W'(1)) && (b_node == a_node + 1'b1);
    assign brr = right_edge ? ar : ar + 1'b1;
    assign bcc = right_edge ? ac + 1'b1 : ac;

    logic [COORD_W-1:0] ar2, ac2, br2, bc2;
    assign ar2 = COORD_W'({ar, 1'b0});
    assign ac2 = COORD_W'({ac, 1'b0});
    assign br2 = COORD_W'({brr, 1'b0});
    assign bc2 = COORD_W'({bcc, 1'b0});

    logic fin_after;
    assign fin_after = started_reg &&
        ((JCNT_W+1)'(jtotal_reg) + 2'd2 >= {1'b0, ntotal_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.res_start || cmd.res_error)
        begin
            res_joined      <= 1'b0;
            res_head_row    <= '0;
            res_head_col    <= '0;
            res_tail_row    <= '0;
            res_tail_col    <= '0;
            res_passage_row <= '0;
            res_passage_col <= '0;
            res_error       <= cmd.res_error;
            res_finished    <= cmd.res_start ? (ntotal_reg == JCNT_W'(1)) : finished_now;
        end
        else if (cmd.join_set)
        begin
            res_error <= 1'b0;
            if (ra_reg != fv_reg)
            begin
                res_joined      <= 1'b1;
                res_head_row    <= ar2;
                res_head_col    <= ac2;
                res_tail_row    <= br2;
                res_tail_col    <= bc2;
                res_passage_row <= COORD_W'(({1'b0, ar2} + {1'b0, br2}) >> 1);
                res_passage_col <= COORD_W'(({1'b0, ac2} + {1'b0, bc2}) >> 1);
                res_finished    <= fin_after;
            end
            else
            begin
                res_joined      <= 1'b0;
                res_head_row    <= '0;
                res_head_col    <= '0;
                res_tail_row    <= '0;
                res_tail_col    <= '0;
                res_passage_row <= '0;
                res_passage_col <= '0;
                res_finished    <= finished_now;
            end
        end
    end

`ifndef ASSERT_OFF
    a_edges_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        etotal_reg <= ECNT_W'(EDGE_CAP))
        else $error("edge count over capacity");
    a_joins_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> jtotal_reg < ntotal_reg)
        else $error("too many joins");
    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_pick |-> {1'b0, rem_reg} < (RND_W+1)'(etotal_reg))
        else $error("pick beyond edge list");
`endif

endmodule

`default_nettype wire

// ----- hdl/random_spanning_tree_maze_carver_core.sv -----
// ----------------------------------------------------------------------------
// random_spanning_tree_maze_carver_core
// randomised kruskal maze carver with union-find sets
// ----------------------------------------------------------------------------
// One item at a time: the input stalls from acceptance until the result beat
// is taken. A start beat lists the edges, visiting each node for its right and
// then its down edge, and then resets the sets one node at a time. A step beat
// runs the bit-serial modulo, closes the gap in the single-port edge list and
// then does the two root searches; the row of the first node is counted
// alongside and may hold the join.
`default_nettype none

module random_spanning_tree_maze_carver_core
    import rstmc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [4:0]   cfg_data,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic         operation,
    input  wire logic [30:0]  random_value,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic              joined,
    output logic [4:0]        head_row,
    output logic [4:0]        head_col,
    output logic [4:0]        tail_row,
    output logic [4:0]        tail_col,
    output logic [4:0]        passage_row,
    output logic [4:0]        passage_col,
    output logic              finished,
    output logic              error
);

    cmd_t cmd;
    sts_t sts;
    logic busy;
    logic in_fire, out_fire;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign in_fire   = in_valid && !busy;
    assign out_fire  = out_valid && !out_stall;

    rstmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_op     (operation),
        .out_fire  (out_fire),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (out_valid)
    );

    rstmc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_fire        (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .rnd             (random_value),
        .sts             (sts),
        .res_joined      (joined),
        .res_head_row    (head_row),
        .res_head_col    (head_col),
        .res_tail_row    (tail_row),
        .res_tail_col    (tail_col),
        .res_passage_row (passage_row),
        .res_passage_col (passage_col),
        .res_finished    (finished),
        .res_error       (error)
    );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// randomised kruskal maze carver: directed and random start/step beats are
// checked against an in-bench union-find predictor under random idling
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import rstmc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct {
        logic        op;
        logic [30:0] rnd;
    } beat_t;

    typedef struct {
        logic       joined;
        logic [4:0] fr, fc, sr, sc, pr, pc;
        logic       fin, err;
    } carve_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_ROWS;
    logic [4:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = OP_START;
    logic [30:0] random_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        joined, finished, error;
    logic [4:0]  head_row, head_col, tail_row, tail_col;
    logic [4:0]  passage_row, passage_col;

    beat_t  pending_beats[$];
    carve_t expected_carves[$];
    int     fail_count = 0;
    int     idle_in_pct = 0;
    int     idle_out_pct = 0;
    int     quiet_cycles = 0;

    // predictor state
    logic [4:0] rows_reg = 5'd31, cols_reg = 5'd31;
    int         edge_a[EDGE_CAP];
    int         edge_b[EDGE_CAP];
    int         parent[NODE_CAP];
    int         edge_cnt = 0, join_cnt = 0, grid_r = 1, grid_c = 1, node_cnt = 1;
    bit         carving = 1'b0;

    random_spanning_tree_maze_carver_core u_dut (.*);

    always #10 clk = ~clk;

    function automatic int nodes_along(logic [4:0] cells, int cap);
        int c;
        int n;
        c = (cells == 0) ? 1 : int'(cells);
        if (c % 2 == 0) c = c - 1;
        n = c / 2 + 1;
        return (n > cap) ? cap : n;
    endfunction

    function automatic int root_of(int v);
        int hops;
        for (hops = 0; hops < NODE_CAP; hops++)
        begin
            if (parent[v] == v) break;
            v = parent[v];
        end
        return v;
    endfunction

    function automatic bit maze_done();
        return carving && (join_cnt + 1 >= node_cnt);
    endfunction

    function automatic void predict_carve(beat_t b);
        carve_t e;
        int     pick, a, bn, x, y, ar, ac, br, bc, i;
        e = '{default: '0};
        if (b.op == OP_START)
        begin
            grid_r = nodes_along(rows_reg, MAX_NODE_ROWS);
            grid_c = nodes_along(cols_reg, MAX_NODE_COLS);
            node_cnt = grid_r * grid_c;
            edge_cnt = 0;
            for (int r = 0; r < grid_r; r++)
                for (int c = 0; c < grid_c; c++)
                begin
                    if (c + 1 < grid_c)
                    begin
                        edge_a[edge_cnt] = r * grid_c + c;
                        edge_b[edge_cnt] = r * grid_c + c + 1;
                        edge_cnt++;
                    end
                    if (r + 1 < grid_r)
                    begin
                        edge_a[edge_cnt] = r * grid_c + c;
                        edge_b[edge_cnt] = r * grid_c + c + grid_c;
                        edge_cnt++;
                    end
                end
            for (i = 0; i < node_cnt; i++) parent[i] = i;
            join_cnt = 0;
            carving = 1'b1;
            e.fin = maze_done();
        end
        else if (!carving || maze_done() || edge_cnt == 0)
        begin
            e.fin = maze_done();
            e.err = 1'b1;
        end
        else
        begin
            pick = int'(b.rnd % edge_cnt);
            a = edge_a[pick];
            bn = edge_b[pick];
            for (i = pick; i < edge_cnt - 1; i++)
            begin
                edge_a[i] = edge_a[i + 1];
                edge_b[i] = edge_b[i + 1];
            end
            edge_cnt--;
            x = root_of(a);
            y = root_of(bn);
            if (x != y)
            begin
                ar = 2 * (a / grid_c);
                ac = 2 * (a % grid_c);
                br = 2 * (bn / grid_c);
                bc = 2 * (bn % grid_c);
                parent[y] = x;
                join_cnt++;
                e.joined = 1'b1;
                e.fr = ar[4:0];
                e.fc = ac[4:0];
                e.sr = br[4:0];
                e.sc = bc[4:0];
                e.pr = 5'((ar + br) / 2);
                e.pc = 5'((ac + bc) / 2);
            end
            e.fin = maze_done();
        end
        expected_carves = {expected_carves, e};
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_carve(pending_beats.pop_front());
                quiet_cycles = 0;
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= idle_in_pct)
                begin
                    in_valid     <= 1'b1;
                    operation    <= pending_beats[0].op;
                    random_value <= pending_beats[0].rnd;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        carve_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                quiet_cycles = 0;
                if (expected_carves.size() == 0)
                begin
                    $display("%0t: unexpected result beat", $realtime);
                    fail_count++;
                end
                else
                begin
                    e = expected_carves.pop_front();
                    if ({joined, head_row, head_col, tail_row, tail_col, passage_row,
                         passage_col, finished, error} !==
                        {e.joined, e.fr, e.fc, e.sr, e.sc, e.pr, e.pc, e.fin, e.err})
                    begin
                        $display({"%0t: mismatch expected j=%0d h=(%0d,%0d) t=(%0d,%0d)",
                                  " p=(%0d,%0d) fin=%0d err=%0d"},
                                 $realtime, e.joined, e.fr, e.fc, e.sr, e.sc, e.pr, e.pc,
                                 e.fin, e.err);
                        $display({"%0t: mismatch actual   j=%0d h=(%0d,%0d) t=(%0d,%0d)",
                                  " p=(%0d,%0d) fin=%0d err=%0d"},
                                 $realtime, joined, head_row, head_col, tail_row,
                                 tail_col, passage_row, passage_col, finished, error);
                        fail_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < idle_out_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_beats.size() > 0 || expected_carves.size() > 0 || in_valid)
            @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        quiet_cycles = 0;
        if (idx == CFG_ROWS) rows_reg = val;
        else cols_reg = val;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [30:0] pick_word();
        case ($urandom_range(3))
            0: return 31'($urandom_range(15));
            1: return $urandom_range(1) ? 31'h7fff_ffff : 31'd0;
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic queue_beat(logic op, logic [30:0] rnd);
        beat_t b;
        b.op  = op;
        b.rnd = rnd;
        pending_beats = {pending_beats, b};
    endtask

    initial
    begin
        int made;
        int phase;
        int nodes;
        int steps;
        logic [4:0] rv, cv;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // step before start, then tiny and degenerate grids
        queue_beat(OP_STEP, 31'h7fff_ffff);
        queue_beat(OP_STEP, 31'd0);
        write_reg(CFG_ROWS, 5'd0);
        write_reg(CFG_COLS, 5'd0);
        queue_beat(OP_START, 31'h5555_5555);
        queue_beat(OP_STEP, 31'h2aaa_aaaa);
        write_reg(CFG_ROWS, 5'd4);
        write_reg(CFG_COLS, 5'd3);
        queue_beat(OP_START, 31'd0);
        for (int i = 0; i < 6; i++)
            queue_beat(OP_STEP, i[0] ? 31'h7fff_ffff : 31'd0);
        write_reg(CFG_ROWS, 5'd1);
        write_reg(CFG_COLS, 5'd31);
        queue_beat(OP_START, 31'd0);
        for (int i = 0; i < 12; i++)
            queue_beat(OP_STEP, pick_word());
        made = 24;

        phase = 0;
        while (made < 800)
        begin
            idle_in_pct  = (phase % 4 == 1 || phase % 4 == 3) ? ((phase % 4 == 1) ? 80 : 23) : 0;
            idle_out_pct = (phase % 4 == 2) ? 80 : ((phase % 4 == 3) ? 23 : 0);
            if (phase % 9 == 8)
            begin
                rv = 5'd31;
                cv = 5'(30 + $urandom_range(1));
            end
            else
            begin
                rv = 5'($urandom_range(9));
                cv = 5'($urandom_range(9));
            end
            write_reg(CFG_ROWS, rv);
            write_reg(CFG_COLS, cv);
            nodes = nodes_along(rv, MAX_NODE_ROWS) * nodes_along(cv, MAX_NODE_COLS);
            queue_beat(OP_START, 31'($urandom));
            steps = 2 * nodes + 2;
            for (int i = 0; i < steps; i++)
            begin
                if ($urandom_range(99) < 2) queue_beat(OP_START, pick_word());
                else queue_beat(OP_STEP, pick_word());
            end
            made += steps + 1;
            phase++;
        end

        wait_drained();
        repeat (1200) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
